// File: src/crc16_frame_receiver_assert.svh
// Assertion macros for the frame receiver.
`ifndef CRC16_FRAME_RECEIVER_ASSERT_SVH
`define CRC16_FRAME_RECEIVER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CFR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CFR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CFR_ASSERT_NOW(label, ante, cons)
`define CFR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: src/cfr_pkg.sv
// Shared types, constants and CRC function for the frame receiver.
package cfr_pkg;
   localparam logic [7:0]  HDR_BYTE      = 8'hE6;
   localparam logic [7:0]  TAIL_BYTE     = 8'h6E;
   localparam logic [15:0] CRC_POLY      = 16'hA001;
   localparam logic [15:0] CRC_INIT      = 16'h0000;
   localparam logic [15:0] CRC_XOROUT    = 16'hFFFF;
   localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_LEN = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CRC_EN  = 1'd1;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_REPORT  = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_LEN_ERR  = 2'd1;
   localparam logic [1:0] STATUS_TAIL_ERR = 2'd2;
   localparam logic [1:0] STATUS_CRC_ERR  = 2'd3;

   typedef enum logic [3:0] {
      PH_HUNT0,
      PH_HUNT1,
      PH_SEQ_HI,
      PH_SEQ_LO,
      PH_CMD,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_PAYLOAD,
      PH_CRC_HI,
      PH_CRC_LO,
      PH_TAIL0,
      PH_TAIL1_OK,
      PH_TAIL1_BAD
   } phase_type;

   typedef struct packed {
      logic [15:0] max_payload_len;
      logic        crc_check_enable;
   } cfg_type;

   typedef struct packed {
      logic        item_kind;
      logic [7:0]  payload_byte;
      logic [1:0]  frame_status;
      logic [15:0] sequence_id;
      logic [7:0]  command_code;
      logic [15:0] payload_len;
      logic        crc_match;
   } result_type;

   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction
endpackage

// File: src/cfr_channels.sv
// Channel interfaces: byte request, result and register write.
interface cfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfr_rsp_if;
   logic        valid;
   logic        ready;
   logic        item_kind;
   logic [7:0]  payload_byte;
   logic [1:0]  frame_status;
   logic [15:0] sequence_id;
   logic [7:0]  command_code;
   logic [15:0] payload_len;
   logic        crc_match;
   modport source (output valid, output item_kind, output payload_byte, output frame_status,
                   output sequence_id, output command_code, output payload_len,
                   output crc_match, input ready);
   modport sink (input valid, input item_kind, input payload_byte, input frame_status,
                 input sequence_id, input command_code, input payload_len,
                 input crc_match, output ready);
endinterface

interface cfr_csr_if;
   logic                               valid;
   logic                               ready;
   logic [cfr_pkg::CSR_INDEX_W-1:0]    index;
   logic [cfr_pkg::CSR_DATA_W-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/cfr_csr.sv
// Configuration registers for the frame receiver.
module cfr_csr (
   input  logic            clock,
   input  logic            reset,
   cfr_csr_if.sink         csr_bus,
   output cfr_pkg::cfg_type cfg
);
   logic [15:0] max_len_ff;
   logic [15:0] max_len_in;
   logic        crc_en_ff;
   logic        crc_en_in;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      max_len_in = max_len_ff;
      crc_en_in  = crc_en_ff;
      if (csr_bus.valid) begin
         if (csr_bus.index == cfr_pkg::REG_MAX_LEN) begin
            max_len_in = csr_bus.data[15:0];
         end else if (csr_bus.index == cfr_pkg::REG_CRC_EN) begin
            crc_en_in = csr_bus.data[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= cfr_pkg::MAX_LEN_RESET;
         crc_en_ff  <= 1'b0;
      end else begin
         max_len_ff <= max_len_in;
         crc_en_ff  <= crc_en_in;
      end
   end

   assign cfg.max_payload_len  = max_len_ff;
   assign cfg.crc_check_enable = crc_en_ff;
endmodule

// File: src/cfr_parser.sv
// Frame parser state machine with byte-wide CRC-16/MAXIM update.
`include "crc16_frame_receiver_assert.svh"
module cfr_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         rx_byte,
   input  cfr_pkg::cfg_type   cfg,
   output logic               res_valid,
   output cfr_pkg::result_type res
);
   cfr_pkg::phase_type phase_ff, phase_in;
   logic [15:0] seq_ff, seq_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] rx_crc_ff, rx_crc_in;
   logic [15:0] crc_next;
   logic        match;
   logic        tail_bad;

   assign crc_next = cfr_pkg::crc_update(crc_ff, rx_byte);
   assign match    = ((crc_ff ^ cfr_pkg::CRC_XOROUT) == rx_crc_ff);
   assign tail_bad = (phase_ff == cfr_pkg::PH_TAIL1_BAD) || (rx_byte != cfr_pkg::TAIL_BYTE);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= cfr_pkg::PH_HUNT0;
         seq_ff    <= '0;
         cmd_ff    <= '0;
         len_ff    <= '0;
         count_ff  <= '0;
         crc_ff    <= '0;
         rx_crc_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         seq_ff    <= seq_in;
         cmd_ff    <= cmd_in;
         len_ff    <= len_in;
         count_ff  <= count_in;
         crc_ff    <= crc_in;
         rx_crc_ff <= rx_crc_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      seq_in    = seq_ff;
      cmd_in    = cmd_ff;
      len_in    = len_ff;
      count_in  = count_ff;
      crc_in    = crc_ff;
      rx_crc_in = rx_crc_ff;
      res_valid = 1'b0;
      res.item_kind    = cfr_pkg::KIND_REPORT;
      res.payload_byte = 8'h00;
      res.frame_status = cfr_pkg::STATUS_OK;
      res.crc_match    = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            cfr_pkg::PH_HUNT0: begin
               if (rx_byte == cfr_pkg::HDR_BYTE) phase_in = cfr_pkg::PH_HUNT1;
            end
            cfr_pkg::PH_HUNT1: begin
               if (rx_byte == cfr_pkg::HDR_BYTE) begin
                  phase_in = cfr_pkg::PH_SEQ_HI;
                  crc_in   = cfr_pkg::CRC_INIT;
                  count_in = '0;
               end else begin
                  phase_in = cfr_pkg::PH_HUNT0;
               end
            end
            cfr_pkg::PH_SEQ_HI: begin
               seq_in   = {rx_byte, 8'h00};
               crc_in   = crc_next;
               phase_in = cfr_pkg::PH_SEQ_LO;
            end
            cfr_pkg::PH_SEQ_LO: begin
               seq_in   = {seq_ff[15:8], rx_byte};
               crc_in   = crc_next;
               phase_in = cfr_pkg::PH_CMD;
            end
            cfr_pkg::PH_CMD: begin
               cmd_in   = rx_byte;
               crc_in   = crc_next;
               phase_in = cfr_pkg::PH_LEN_HI;
            end
            cfr_pkg::PH_LEN_HI: begin
               len_in   = {rx_byte, 8'h00};
               crc_in   = crc_next;
               phase_in = cfr_pkg::PH_LEN_LO;
            end
            cfr_pkg::PH_LEN_LO: begin
               len_in   = {len_ff[15:8], rx_byte};
               crc_in   = crc_next;
               count_in = '0;
               if (len_in > cfg.max_payload_len) begin
                  phase_in         = cfr_pkg::PH_HUNT0;
                  res_valid        = 1'b1;
                  res.frame_status = cfr_pkg::STATUS_LEN_ERR;
               end else if (len_in == 16'd0) begin
                  phase_in = cfr_pkg::PH_CRC_HI;
               end else begin
                  phase_in = cfr_pkg::PH_PAYLOAD;
               end
            end
            cfr_pkg::PH_PAYLOAD: begin
               crc_in   = crc_next;
               count_in = count_ff + 16'd1;
               if (count_in >= len_ff) phase_in = cfr_pkg::PH_CRC_HI;
               res_valid        = 1'b1;
               res.item_kind    = cfr_pkg::KIND_PAYLOAD;
               res.payload_byte = rx_byte;
            end
            cfr_pkg::PH_CRC_HI: begin
               rx_crc_in = {rx_byte, 8'h00};
               phase_in  = cfr_pkg::PH_CRC_LO;
            end
            cfr_pkg::PH_CRC_LO: begin
               rx_crc_in = {rx_crc_ff[15:8], rx_byte};
               phase_in  = cfr_pkg::PH_TAIL0;
            end
            cfr_pkg::PH_TAIL0: begin
               phase_in = (rx_byte == cfr_pkg::TAIL_BYTE) ? cfr_pkg::PH_TAIL1_OK
                                                          : cfr_pkg::PH_TAIL1_BAD;
            end
            cfr_pkg::PH_TAIL1_OK, cfr_pkg::PH_TAIL1_BAD: begin
               phase_in      = cfr_pkg::PH_HUNT0;
               res_valid     = 1'b1;
               res.crc_match = match;
               if (tail_bad) begin
                  res.frame_status = cfr_pkg::STATUS_TAIL_ERR;
               end else if (cfg.crc_check_enable && !match) begin
                  res.frame_status = cfr_pkg::STATUS_CRC_ERR;
               end else begin
                  res.frame_status = cfr_pkg::STATUS_OK;
               end
            end
            default: begin
               phase_in = cfr_pkg::PH_HUNT0;
            end
         endcase
      end
      res.sequence_id  = seq_in;
      res.command_code = cmd_in;
      res.payload_len  = len_in;
   end

   `CFR_ASSERT_NOW(a_payload_count, phase_ff == cfr_pkg::PH_PAYLOAD, count_ff < len_ff)
   `CFR_ASSERT_NOW(a_idle_holds, !accept, phase_in == phase_ff && crc_in == crc_ff)
   `CFR_ASSERT_NEXT(a_len_err_hunt, res_valid && res.frame_status == cfr_pkg::STATUS_LEN_ERR,
                    phase_ff == cfr_pkg::PH_HUNT0)
endmodule

// File: src/crc16_frame_receiver.sv
// Frame receiver top level: parser, configuration registers, result register.
// A result appears on rsp_bus in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle unless rsp_bus stalls; the result register refills in the cycle it is drained.
// Bytes that cause no result (such as header, CRC and first tail byte) only advance the parser state.
// Reset (synchronous): parser to header hunt, fields to zero, no result pending,
// max_payload_len to 1024 and crc_check_enable to 0.
`include "crc16_frame_receiver_assert.svh"
module crc16_frame_receiver (
   input  logic     clock,
   input  logic     reset,
   cfr_req_if.sink  req_bus,
   cfr_rsp_if.source rsp_bus,
   cfr_csr_if.sink  csr_bus
);
   cfr_pkg::cfg_type    cfg;
   cfr_pkg::result_type res;
   cfr_pkg::result_type out_ff, out_in;
   logic                res_valid;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;

   cfr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   cfr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_bus.rx_byte),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = res_valid;
         if (res_valid) out_in = res;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.item_kind    = out_ff.item_kind;
   assign rsp_bus.payload_byte = out_ff.payload_byte;
   assign rsp_bus.frame_status = out_ff.frame_status;
   assign rsp_bus.sequence_id  = out_ff.sequence_id;
   assign rsp_bus.command_code = out_ff.command_code;
   assign rsp_bus.payload_len  = out_ff.payload_len;
   assign rsp_bus.crc_match    = out_ff.crc_match;

   `CFR_ASSERT_NOW(a_full_blocks, rsp_valid_ff && !rsp_bus.ready, !req_bus.ready)
   `CFR_ASSERT_NEXT(a_result_loaded, accept && res_valid, rsp_valid_ff)
   `CFR_ASSERT_NOW(a_payload_clean,
                   rsp_valid_ff && out_ff.item_kind == cfr_pkg::KIND_PAYLOAD,
                   out_ff.frame_status == cfr_pkg::STATUS_OK && !out_ff.crc_match)
endmodule
